// ===== rtl/plb_pkg.sv =====
// plb_pkg: shared types, constants and window address helpers for the plasma layer blender.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package plb_pkg;

   // Frame geometry
   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 128;
   localparam int MAP_DEPTH    = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ROW_W        = $clog2(FRAME_HEIGHT);
   localparam int COL_W        = $clog2(FRAME_WIDTH);
   localparam int ADDR_W       = $clog2(MAP_DEPTH);

   // Field widths fixed by the transaction format
   localparam int POS_W      = 7;
   localparam int BYTE_W     = 8;
   localparam int WSUM_W     = POS_W + 1;      // position plus offset
   localparam int WSUM_DEPTH = 1 << WSUM_W;
   localparam int BLEND_W    = BYTE_W + 2;     // sum of four bytes
   localparam logic [BYTE_W-1:0] SAT_MAX = 8'hFF;

   // Configuration registers
   localparam int NUM_REGS  = 8;
   localparam int CFG_SEL_W = $clog2(NUM_REGS);
   localparam int CSR_IDX_W = 4;
   localparam int CFG_W     = 7;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd32;

   localparam int REG_DIST_COL   = 0;
   localparam int REG_DIST_ROW   = 1;
   localparam int REG_WAVE_A_COL = 2;
   localparam int REG_WAVE_A_ROW = 3;
   localparam int REG_WAVE_B_COL = 4;
   localparam int REG_WAVE_B_ROW = 5;
   localparam int REG_WAVE_C_COL = 6;
   localparam int REG_WAVE_C_ROW = 7;

   // Request codes
   typedef enum logic [1:0] {
      REQ_WR_DIST = 2'd0,
      REQ_WR_WAVE = 2'd1,
      REQ_RENDER  = 2'd2
   } req_code_type;

   typedef logic [ADDR_W-1:0] map_addr_type;
   typedef logic [BYTE_W-1:0] map_byte_type;

   // Map store command group
   typedef struct packed {
      logic         dist_wr;
      logic         wave_wr;
      map_addr_type wr_addr;
      map_byte_type wr_data;
      logic         rd_en;
      map_addr_type dist_rd_addr;
      map_addr_type wave_a_rd_addr;
      map_addr_type wave_b_rd_addr;
      map_addr_type wave_c_rd_addr;
   } map_cmd_type;

   // Map store read data group
   typedef struct packed {
      map_byte_type dist_val;
      map_byte_type wave_a;
      map_byte_type wave_b;
      map_byte_type wave_c;
   } map_data_type;

   // Wrap tables for window coordinates, built at elaboration
   typedef logic [ROW_W-1:0] row_wrap_tbl_type [WSUM_DEPTH];
   typedef logic [COL_W-1:0] col_wrap_tbl_type [WSUM_DEPTH];

   function automatic row_wrap_tbl_type build_row_wrap();
      row_wrap_tbl_type t;
      for (int i = 0; i < WSUM_DEPTH; i++) begin
         t[i] = ROW_W'(i % FRAME_HEIGHT);
      end
      return t;
   endfunction

   function automatic col_wrap_tbl_type build_col_wrap();
      col_wrap_tbl_type t;
      for (int i = 0; i < WSUM_DEPTH; i++) begin
         t[i] = COL_W'(i % FRAME_WIDTH);
      end
      return t;
   endfunction

   localparam row_wrap_tbl_type ROW_WRAP = build_row_wrap();
   localparam col_wrap_tbl_type COL_WRAP = build_col_wrap();

   // Map address of a window entry, wrapping at the frame edges
   function automatic map_addr_type window_addr(input logic [POS_W-1:0] row,
                                                input logic [POS_W-1:0] col,
                                                input logic [CFG_W-1:0] row_off,
                                                input logic [CFG_W-1:0] col_off);
      logic [WSUM_W-1:0] rs;
      logic [WSUM_W-1:0] cs;
      rs = WSUM_W'(row) + WSUM_W'(row_off);
      cs = WSUM_W'(col) + WSUM_W'(col_off);
      return ADDR_W'(ROW_WRAP[rs]) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(COL_WRAP[cs]);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/plb_channels.sv =====
// plb_channels: valid/ready channel interfaces for requests, responses and CSR writes.
// Depends on plb_pkg for field widths.
`default_nettype none

interface plb_req_if import plb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [POS_W-1:0] pix_row;
   logic [POS_W-1:0] pix_col;
   logic [BYTE_W-1:0] map_byte;

   modport source (output valid, output req_type, output pix_row, output pix_col,
                   output map_byte, input ready);
   modport sink   (input valid, input req_type, input pix_row, input pix_col,
                   input map_byte, output ready);
endinterface

interface plb_rsp_if import plb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] blended_pixel;
   logic              clamped;

   modport source (output valid, output blended_pixel, output clamped, input ready);
   modport sink   (input valid, input blended_pixel, input clamped, output ready);
endinterface

interface plb_csr_if import plb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CFG_W-1:0]     wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/plb_map_store.sv =====
// plb_map_store: distance map and two copies of the wave map, one write and four reads a cycle.
// Depends on plb_pkg for the command and data structs.
`default_nettype none

module plb_map_store import plb_pkg::*; (
   input  wire logic         clock,
   input  wire map_cmd_type  cmd,
   output map_data_type      rd_data_ff
);

   // Wave map kept twice so that three window reads fit two read ports
   map_byte_type dist_mem   [MAP_DEPTH];
   map_byte_type wave_ab_mem[MAP_DEPTH];
   map_byte_type wave_c_mem [MAP_DEPTH];

   // Write port: both wave copies take the same transaction
   always_ff @(posedge clock) begin
      if (cmd.dist_wr) begin
         dist_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.wave_wr) begin
         wave_ab_mem[cmd.wr_addr] <= cmd.wr_data;
         wave_c_mem[cmd.wr_addr]  <= cmd.wr_data;
      end
   end

   // Registered reads; hold while no render is issued
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff.dist_val <= dist_mem[cmd.dist_rd_addr];
         rd_data_ff.wave_a   <= wave_ab_mem[cmd.wave_a_rd_addr];
         rd_data_ff.wave_b   <= wave_ab_mem[cmd.wave_b_rd_addr];
         rd_data_ff.wave_c   <= wave_c_mem[cmd.wave_c_rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/plasma_layer_blend.sv =====
// plasma_layer_blend: top level of the plasma layer blender.
// Depends on plb_pkg, the channel interfaces and plb_map_store.
//
//   channel  direction  carries                                  accepted when
//   req      in         req_type, pix_row, pix_col, map_byte     valid & ready
//   rsp      out        blended_pixel, clamped                   valid & ready
//   csr      in         reg_index, wr_data                       valid & ready
//
// One request transaction per cycle while req ready is high. A render reads all four window
// bytes together from the map memories into the registered read stage and then moves
// into the output register, where its response is valid, once the output register is
// free or draining.
// Map writes take effect at acceptance and give no response.
// Reset clears the pipeline and sets all offsets to 32; map contents are not cleared.
// A stalled response holds the output register; requests keep flowing until the
// read stage is also full.
`default_nettype none

module plasma_layer_blend import plb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   plb_req_if.sink   req_port,
   plb_rsp_if.source rsp_port,
   plb_csr_if.sink   csr_port
);

   // Offset registers
   logic [CFG_W-1:0] cfg_ff [NUM_REGS];

   logic         s1_valid_ff, s1_valid_in;
   logic         out_valid_ff, out_valid_in;
   map_byte_type out_pixel_ff;
   logic         out_clamped_ff;
   logic         s1_adv;
   logic         req_acc;
   logic         render_acc;
   logic         in_frame;
   map_cmd_type  map_cmd;
   map_data_type map_rd_ff;
   logic [BLEND_W-1:0] blend_sum;

   // Take CSR writes at any time; drop indexes beyond the register list
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cfg_ff[i] <= CFG_RESET;
         end
      end else if (csr_port.valid && csr_port.reg_index < CSR_IDX_W'(NUM_REGS)) begin
         cfg_ff[csr_port.reg_index[CFG_SEL_W-1:0]] <= csr_port.wr_data;
      end
   end

   // Handshake: the read stage moves on when the output register is free or draining
   assign s1_adv         = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = !s1_valid_ff || s1_adv;
   assign req_acc        = req_port.valid && req_port.ready;

   assign in_frame = (32'(req_port.pix_row) < FRAME_HEIGHT) &&
                     (32'(req_port.pix_col) < FRAME_WIDTH);

   // Decode the request transaction into memory commands
   always_comb begin
      map_cmd         = '0;
      render_acc      = 1'b0;
      map_cmd.wr_addr = ADDR_W'(req_port.pix_row) * ADDR_W'(FRAME_WIDTH) +
                        ADDR_W'(req_port.pix_col);
      map_cmd.wr_data = req_port.map_byte;
      map_cmd.dist_rd_addr = window_addr(req_port.pix_row, req_port.pix_col,
                                         cfg_ff[REG_DIST_ROW], cfg_ff[REG_DIST_COL]);
      map_cmd.wave_a_rd_addr = window_addr(req_port.pix_row, req_port.pix_col,
                                           cfg_ff[REG_WAVE_A_ROW], cfg_ff[REG_WAVE_A_COL]);
      map_cmd.wave_b_rd_addr = window_addr(req_port.pix_row, req_port.pix_col,
                                           cfg_ff[REG_WAVE_B_ROW], cfg_ff[REG_WAVE_B_COL]);
      map_cmd.wave_c_rd_addr = window_addr(req_port.pix_row, req_port.pix_col,
                                           cfg_ff[REG_WAVE_C_ROW], cfg_ff[REG_WAVE_C_COL]);
      if (req_acc) begin
         unique case (req_port.req_type)
            REQ_WR_DIST: map_cmd.dist_wr = in_frame;
            REQ_WR_WAVE: map_cmd.wave_wr = in_frame;
            REQ_RENDER:  render_acc      = 1'b1;
            default:     render_acc      = 1'b0;
         endcase
      end
      map_cmd.rd_en = render_acc;
   end

   plb_map_store u_map_store (
      .clock      (clock),
      .cmd        (map_cmd),
      .rd_data_ff (map_rd_ff)
   );

   // Blend the four window bytes and saturate
   assign blend_sum = BLEND_W'(map_rd_ff.dist_val) + BLEND_W'(map_rd_ff.wave_a) +
                      BLEND_W'(map_rd_ff.wave_b) + BLEND_W'(map_rd_ff.wave_c);

   // Advance the pipeline valid bits
   always_comb begin
      s1_valid_in  = s1_valid_ff && !s1_adv;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
      end
      if (render_acc) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the output register when the read stage advances
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         out_clamped_ff <= (blend_sum[BLEND_W-1:BYTE_W] != '0);
         out_pixel_ff   <= (blend_sum[BLEND_W-1:BYTE_W] != '0) ? SAT_MAX
                                                               : blend_sum[BYTE_W-1:0];
      end
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.blended_pixel = out_pixel_ff;
   assign rsp_port.clamped       = out_clamped_ff;

   // A render always occupies the read stage in the next cycle
   a_render_fills_s1: assert property (@(posedge clock) disable iff (reset)
      render_acc |=> s1_valid_ff)
      else $error("render transaction did not enter the read stage");

   // A blocked read stage keeps its item
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("read stage item lost under stall");

   // Requests are refused only when both stages are full
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> (s1_valid_ff && out_valid_ff))
      else $error("request refused with room in the pipeline");

   // A clamped response carries the saturated value
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_clamped_ff) |-> (out_pixel_ff == SAT_MAX))
      else $error("clamped response without saturated pixel");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking testbench for plasma_layer_blend (map loads, window renders, offsets).
// Depends on plb_pkg, the plb_channels interfaces and plasma_layer_blend.
`timescale 1ns / 1ps

module tb;
   import plb_pkg::*;

   localparam int CYCLE_LIMIT   = 100000;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_MAX    = 10;
   localparam int HOLD_CYCLES   = 200;
   // request code the block must drop
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // register indexes past the end of the offset list
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_FIRST = CSR_IDX_W'(NUM_REGS);
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LAST  = {CSR_IDX_W{1'b1}};

   typedef struct packed {
      logic [1:0]        kind;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [BYTE_W-1:0] data;
   } pixel_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic              clamped;
   } blend_result_type;

   logic clock;
   logic reset;

   plb_req_if req_ch ();
   plb_rsp_if rsp_ch ();
   plb_csr_if csr_ch ();

   plasma_layer_blend u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   // shadow copy of the block state
   logic [BYTE_W-1:0] dist_shadow [MAP_DEPTH];
   logic [BYTE_W-1:0] wave_shadow [MAP_DEPTH];
   logic [CFG_W-1:0]  offset_shadow [NUM_REGS];
   // entries already queued for a write, so renders never read an unwritten byte
   bit                dist_planned [MAP_DEPTH];
   bit                wave_planned [MAP_DEPTH];

   pixel_req_type    req_backlog [$];
   blend_result_type pixel_expect_q [$];
   pixel_req_type    next_req;
   blend_result_type want_pixel;

   logic req_fire;
   logic rsp_hold;
   logic hold_kick;
   int   hold_left;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   mismatch_count;
   int   cycle_count;

   // map index of a window entry, wrapping at the frame edges
   function automatic int window_index(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                       logic [CFG_W-1:0] row_off, logic [CFG_W-1:0] col_off);
      int r;
      int c;
      r = (int'(row) + int'(row_off)) % FRAME_HEIGHT;
      c = (int'(col) + int'(col_off)) % FRAME_WIDTH;
      return r * FRAME_WIDTH + c;
   endfunction

   // sum the four window bytes and saturate
   function automatic blend_result_type blend_predict(logic [POS_W-1:0] row,
                                                      logic [POS_W-1:0] col);
      int               total;
      blend_result_type res;
      total = int'(dist_shadow[window_index(row, col, offset_shadow[REG_DIST_ROW],
                                            offset_shadow[REG_DIST_COL])])
            + int'(wave_shadow[window_index(row, col, offset_shadow[REG_WAVE_A_ROW],
                                            offset_shadow[REG_WAVE_A_COL])])
            + int'(wave_shadow[window_index(row, col, offset_shadow[REG_WAVE_B_ROW],
                                            offset_shadow[REG_WAVE_B_COL])])
            + int'(wave_shadow[window_index(row, col, offset_shadow[REG_WAVE_C_ROW],
                                            offset_shadow[REG_WAVE_C_COL])]);
      res.clamped = (total > int'(SAT_MAX));
      res.pixel   = res.clamped ? SAT_MAX : BYTE_W'(total);
      return res;
   endfunction

   // bias map bytes low so that sums land near the clamp point
   function automatic logic [BYTE_W-1:0] pick_map_byte();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return SAT_MAX;
      if (r < 45) return BYTE_W'($urandom_range(255));
      return BYTE_W'($urandom_range(90));
   endfunction

   task automatic push_req(logic [1:0] kind, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                           logic [BYTE_W-1:0] data);
      pixel_req_type item;
      item.kind = kind;
      item.row  = row;
      item.col  = col;
      item.data = data;
      req_backlog.push_back(item);
      if (kind == REQ_WR_DIST) dist_planned[int'(row) * FRAME_WIDTH + int'(col)] = 1'b1;
      if (kind == REQ_WR_WAVE) wave_planned[int'(row) * FRAME_WIDTH + int'(col)] = 1'b1;
   endtask

   // queue a render, preceded by writes to any of its window entries not yet loaded
   task automatic push_render(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
      int d;
      int wa;
      int wb;
      int wc;
      d  = window_index(row, col, offset_shadow[REG_DIST_ROW], offset_shadow[REG_DIST_COL]);
      wa = window_index(row, col, offset_shadow[REG_WAVE_A_ROW],
                        offset_shadow[REG_WAVE_A_COL]);
      wb = window_index(row, col, offset_shadow[REG_WAVE_B_ROW],
                        offset_shadow[REG_WAVE_B_COL]);
      wc = window_index(row, col, offset_shadow[REG_WAVE_C_ROW],
                        offset_shadow[REG_WAVE_C_COL]);
      if (!dist_planned[d])
         push_req(REQ_WR_DIST, POS_W'(d / FRAME_WIDTH), POS_W'(d % FRAME_WIDTH),
                  pick_map_byte());
      if (!wave_planned[wa])
         push_req(REQ_WR_WAVE, POS_W'(wa / FRAME_WIDTH), POS_W'(wa % FRAME_WIDTH),
                  pick_map_byte());
      if (!wave_planned[wb])
         push_req(REQ_WR_WAVE, POS_W'(wb / FRAME_WIDTH), POS_W'(wb % FRAME_WIDTH),
                  pick_map_byte());
      if (!wave_planned[wc])
         push_req(REQ_WR_WAVE, POS_W'(wc / FRAME_WIDTH), POS_W'(wc % FRAME_WIDTH),
                  pick_map_byte());
      push_req(REQ_RENDER, row, col, BYTE_W'($urandom_range(255)));
   endtask

   // corner of a small block of render pixels, mostly inside the half-size output
   task automatic pick_pool(output logic [POS_W-1:0] base_row,
                            output logic [POS_W-1:0] base_col);
      if ($urandom_range(99) < 70) begin
         base_row = POS_W'($urandom_range(60));
         base_col = POS_W'($urandom_range(60));
      end else begin
         base_row = POS_W'($urandom_range(127));
         base_col = POS_W'($urandom_range(127));
      end
   endtask

   task automatic note_mismatch(string what, blend_result_type want,
                                logic [BYTE_W-1:0] got_pixel, logic got_clamped);
      if (mismatch_count < REPORT_MAX) begin
         $display("[%0t] %s: expected pixel=%0d clamped=%0d, got pixel=%0d clamped=%0d",
                  $realtime, what, want.pixel, want.clamped, got_pixel, got_clamped);
      end
      mismatch_count++;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data   <= data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic program_offsets(int lo, int hi);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_write(CSR_IDX_W'(i), CFG_W'($urandom_range(hi, lo)));
      end
   endtask

   // hold until the backlog is sent and every pixel is back, then let the pipe drain
   task automatic settle();
      while (req_backlog.size() != 0 || req_ch.valid || pixel_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mixed traffic: mostly renders and map updates, a few dropped codes
   task automatic run_traffic(int count);
      int               r;
      logic [POS_W-1:0] base_row;
      logic [POS_W-1:0] base_col;
      pick_pool(base_row, base_col);
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            push_render(base_row + POS_W'($urandom_range(3)),
                        base_col + POS_W'($urandom_range(3)));
         end else if (r < 95) begin
            push_req((r < 72) ? REQ_WR_WAVE : REQ_WR_DIST, POS_W'($urandom_range(127)),
                     POS_W'($urandom_range(127)), pick_map_byte());
         end else begin
            push_req(REQ_UNUSED, POS_W'($urandom_range(127)), POS_W'($urandom_range(127)),
                     BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // request driver: hold an offered transaction until taken, idle at random
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = req_backlog.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.req_type <= next_req.kind;
            req_ch.pix_row  <= next_req.row;
            req_ch.pix_col  <= next_req.col;
            req_ch.map_byte <= next_req.data;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // long hold-off of the response side, counted down once kicked
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   assign rsp_hold = (hold_left != 0);

   // response sink: random back-pressure plus the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: track offsets and maps, predict renders, check pixels
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;

         if (csr_ch.valid && csr_ch.ready && csr_ch.reg_index < NUM_REGS) begin
            offset_shadow[csr_ch.reg_index[CFG_SEL_W-1:0]] = csr_ch.wr_data;
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixel_expect_q.size() == 0) begin
               note_mismatch("unexpected pixel", '0, rsp_ch.blended_pixel, rsp_ch.clamped);
            end else begin
               want_pixel = pixel_expect_q.pop_front();
               if (rsp_ch.blended_pixel !== want_pixel.pixel ||
                   rsp_ch.clamped !== want_pixel.clamped) begin
                  note_mismatch("pixel mismatch", want_pixel, rsp_ch.blended_pixel,
                                rsp_ch.clamped);
               end
            end
         end

         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.req_type)
               REQ_WR_DIST: begin
                  if (int'(req_ch.pix_row) < FRAME_HEIGHT && int'(req_ch.pix_col) < FRAME_WIDTH)
                     dist_shadow[int'(req_ch.pix_row) * FRAME_WIDTH + int'(req_ch.pix_col)] =
                        req_ch.map_byte;
               end
               REQ_WR_WAVE: begin
                  if (int'(req_ch.pix_row) < FRAME_HEIGHT && int'(req_ch.pix_col) < FRAME_WIDTH)
                     wave_shadow[int'(req_ch.pix_row) * FRAME_WIDTH + int'(req_ch.pix_col)] =
                        req_ch.map_byte;
               end
               REQ_RENDER: begin
                  pixel_expect_q.push_back(blend_predict(req_ch.pix_row, req_ch.pix_col));
               end
               default: ;
            endcase
         end

         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      logic [POS_W-1:0] pool_row;
      logic [POS_W-1:0] pool_col;
      reset            = 1'b1;
      hold_kick        = 1'b0;
      send_idle_pct    = 28;
      recv_idle_pct    = 68;
      mismatch_count   = 0;
      cycle_count      = 0;
      req_fire         = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = '0;
      req_ch.pix_row   = '0;
      req_ch.pix_col   = '0;
      req_ch.map_byte  = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wr_data   = '0;
      for (int i = 0; i < NUM_REGS; i++) offset_shadow[i] = CFG_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // distinct windows: zero, mid and full-wrap offsets; unmapped indexes do nothing
      csr_write(CSR_IDX_W'(REG_DIST_COL), CFG_W'(0));
      csr_write(CSR_IDX_W'(REG_DIST_ROW), CFG_W'(0));
      csr_write(CSR_IDX_W'(REG_WAVE_A_COL), CFG_W'(0));
      csr_write(CSR_IDX_W'(REG_WAVE_A_ROW), CFG_W'(0));
      csr_write(CSR_IDX_W'(REG_WAVE_B_COL), CFG_W'(64));
      csr_write(CSR_IDX_W'(REG_WAVE_B_ROW), CFG_W'(64));
      csr_write(CSR_IDX_W'(REG_WAVE_C_COL), CFG_W'(127));
      csr_write(CSR_IDX_W'(REG_WAVE_C_ROW), CFG_W'(127));
      csr_write(REG_UNMAPPED_FIRST, '0);
      csr_write(REG_UNMAPPED_LAST, {CFG_W{1'b1}});

      // pixel (5,5) reads dist (5,5), wave (5,5), (69,69) and (4,4); each group of writes
      // is followed straight away by the render that reads them
      push_req(REQ_WR_DIST, 7'd5, 7'd5, 8'hFF);
      push_req(REQ_WR_WAVE, 7'd5, 7'd5, 8'hFF);
      push_req(REQ_WR_WAVE, 7'd69, 7'd69, 8'hFF);
      push_req(REQ_WR_WAVE, 7'd4, 7'd4, 8'hFF);
      push_render(7'd5, 7'd5);
      push_req(REQ_WR_DIST, 7'd5, 7'd5, 8'h00);
      push_req(REQ_WR_WAVE, 7'd5, 7'd5, 8'h00);
      push_req(REQ_WR_WAVE, 7'd69, 7'd69, 8'h00);
      push_req(REQ_WR_WAVE, 7'd4, 7'd4, 8'h00);
      push_render(7'd5, 7'd5);
      push_req(REQ_WR_DIST, 7'd5, 7'd5, 8'hFF);
      push_render(7'd5, 7'd5);
      push_req(REQ_WR_WAVE, 7'd4, 7'd4, 8'h01);
      push_render(7'd5, 7'd5);
      push_req(REQ_UNUSED, 7'd127, 7'd127, 8'hFF);
      push_req(REQ_WR_DIST, 7'd127, 7'd127, 8'hAA);
      push_req(REQ_WR_WAVE, 7'd0, 7'd0, 8'h55);
      push_render(7'd127, 7'd127);
      push_render(7'd0, 7'd0);
      push_render(7'd63, 7'd63);
      push_render(7'd127, 7'd0);
      push_render(7'd0, 7'd127);
      settle();

      // sender light idling, receiver heavy back-pressure
      program_offsets(0, 64);
      run_traffic(300);
      settle();

      // roles swapped, all windows at zero offset
      send_idle_pct = 68;
      recv_idle_pct = 28;
      program_offsets(0, 0);
      run_traffic(300);
      settle();

      // full rate, maximum offsets
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_offsets(127, 127);
      run_traffic(160);
      settle();

      // block the response side while renders keep coming, so the input stalls
      pick_pool(pool_row, pool_col);
      for (int i = 0; i < 100; i++) begin
         push_render(pool_row + POS_W'($urandom_range(3)), pool_col + POS_W'($urandom_range(3)));
      end
      @(negedge clock);
      hold_kick = 1'b1;
      @(negedge clock);
      hold_kick = 1'b0;
      wait (hold_left == 0);
      settle();

      program_offsets(64, 64);
      run_traffic(160);
      settle();

      if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/plb_pkg.sv
rtl/plb_channels.sv
rtl/plb_map_store.sv
rtl/plasma_layer_blend.sv
sim/tb.sv
